// ===== rtl/fmsc_pkg.sv =====
`timescale 1ns / 1ps

package fmsc_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int TEMP_W   = 15;
    localparam int HUM_W    = 14;
    localparam int VAL_W    = 7;
    localparam int DUTY_W   = 7;
    localparam int MODE_W   = 2;
    localparam int STAT_W   = 2;
    localparam int TTH_W    = 8;
    localparam int HTH_W    = 9;
    localparam int CIDX_W   = 2;
    localparam int CDATA_W  = 9;
    localparam int CMP_W    = 17;   // signed width for the hundredths compares

    // Packed stream widths, padded to whole bytes
    localparam int IN_BITS    = 1 + TEMP_W + HUM_W + 1 + VAL_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = DUTY_W + 1 + MODE_W + DUTY_W + STAT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Ramp timing
    localparam int RAMP_PERIOD = 10000;
    localparam int RAMP_W      = $clog2(RAMP_PERIOD);

    // Numeric limits
    localparam logic [DUTY_W-1:0] DUTY_MAX    = DUTY_W'(99);
    localparam logic [DUTY_W-1:0] BUTTON_TOP  = DUTY_W'(80);
    localparam logic [DUTY_W-1:0] BUTTON_STEP = DUTY_W'(20);
    localparam logic signed [CMP_W-1:0] HUNDRED = CMP_W'(100);

    // Configuration reset values
    localparam logic [TTH_W-1:0]  TTH_RESET      = TTH_W'(30);
    localparam logic [HTH_W-1:0]  HTH_RESET      = HTH_W'(80);
    localparam logic [DUTY_W-1:0] STRENGTH_RESET = DUTY_W'(50);

    // LED control codes
    localparam logic [VAL_W-1:0] LED_OFF    = VAL_W'(0);
    localparam logic [VAL_W-1:0] LED_ON     = VAL_W'(1);
    localparam logic [VAL_W-1:0] LED_UNLOCK = VAL_W'(2);

    typedef enum logic [CIDX_W-1:0] {
        CFG_TEMP_TH  = 2'd0,
        CFG_HUM_TH   = 2'd1,
        CFG_STRENGTH = 2'd2
    } t_cfg_idx;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 2'd0,
        CMD_SET_SPEED = 2'd1,
        CMD_LED       = 2'd2,
        CMD_SET_MODE  = 2'd3
    } t_cmd;

    typedef enum logic [MODE_W-1:0] {
        MODE_PRESENCE  = 2'd0,
        MODE_THRESHOLD = 2'd1,
        MODE_MANUAL    = 2'd2
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LED  = 2'd1,
        ST_BAD_MODE = 2'd2
    } t_status;

    // Configuration registers as seen by the core
    typedef struct packed {
        logic signed [TTH_W-1:0] temp_th;
        logic signed [HTH_W-1:0] hum_th;
        logic [DUTY_W-1:0]       strength;
    } t_cfg;

    // One input transaction
    typedef struct packed {
        t_cmd                     command;
        logic                     presence;
        logic signed [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]         humidity;
        logic                     button_pressed;
        logic [VAL_W-1:0]         setting_value;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic [DUTY_W-1:0] fan_duty;
        logic              fan_led;
        logic [MODE_W-1:0] current_mode;
        logic [DUTY_W-1:0] speed_setting;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

// ===== rtl/fmsc_cfg_regs.sv =====
`timescale 1ns / 1ps

module fmsc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [fmsc_pkg::CIDX_W-1:0]     i_cfg_index,
    input  logic [fmsc_pkg::CDATA_W-1:0]    i_cfg_data,
    output logic                            o_cfg_ready,
    output fmsc_pkg::t_cfg                  o_cfg
);

    logic signed [fmsc_pkg::TTH_W-1:0] r_temp_th;
    logic signed [fmsc_pkg::HTH_W-1:0] r_hum_th;
    logic [fmsc_pkg::DUTY_W-1:0]       r_strength;
    logic [fmsc_pkg::DUTY_W-1:0]       w_strength_sat;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_th  <= fmsc_pkg::TTH_RESET;
            r_hum_th   <= fmsc_pkg::HTH_RESET;
            r_strength <= fmsc_pkg::STRENGTH_RESET;
        end else if (i_cfg_valid) begin
            unique case (fmsc_pkg::t_cfg_idx'(i_cfg_index))
                fmsc_pkg::CFG_TEMP_TH:  r_temp_th  <= i_cfg_data[fmsc_pkg::TTH_W-1:0];
                fmsc_pkg::CFG_HUM_TH:   r_hum_th   <= i_cfg_data[fmsc_pkg::HTH_W-1:0];
                fmsc_pkg::CFG_STRENGTH: r_strength <= i_cfg_data[fmsc_pkg::DUTY_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // Strength above full scale acts as full scale
    assign w_strength_sat = (r_strength > fmsc_pkg::DUTY_MAX) ? fmsc_pkg::DUTY_MAX : r_strength;

    assign o_cfg.temp_th  = r_temp_th;
    assign o_cfg.hum_th   = r_hum_th;
    assign o_cfg.strength = w_strength_sat;

endmodule

// ===== rtl/fmsc_in_stage.sv =====
`timescale 1ns / 1ps

module fmsc_in_stage (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  fmsc_pkg::t_item         i_item,
    output logic                    o_ready,
    input  logic                    i_take,     // core consumes the held item
    output logic                    o_valid,
    output fmsc_pkg::t_item         o_item
);

    logic            r_valid;
    fmsc_pkg::t_item r_item;

    // Room when empty or when the held item leaves this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/fmsc_core.sv =====
`timescale 1ns / 1ps

module fmsc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fmsc_pkg::t_cfg      i_cfg,
    input  logic                i_fire,     // held item is processed this cycle
    input  fmsc_pkg::t_item     i_item,
    output fmsc_pkg::t_result   o_result
);

    // Outcome of one application of the mode rule
    typedef struct packed {
        logic [fmsc_pkg::DUTY_W-1:0] speed;
        logic [fmsc_pkg::DUTY_W-1:0] duty;
        logic                        led;
    } t_rule;

    fmsc_pkg::t_mode                r_mode, n_mode;
    logic [fmsc_pkg::DUTY_W-1:0]    r_speed, n_speed;
    logic [fmsc_pkg::RAMP_W-1:0]    r_ramp, n_ramp;
    logic                           r_lock, n_lock;
    logic                           r_led, n_led;
    logic [fmsc_pkg::DUTY_W-1:0]    r_duty, n_duty;
    fmsc_pkg::t_status              w_status;

    logic signed [fmsc_pkg::CMP_W-1:0] w_temp_lim, w_hum_lim, w_temp, w_hum;
    logic                              w_hot;
    t_rule                             w_rule_a, w_rule_b;
    logic [fmsc_pkg::DUTY_W-1:0]       w_speed_r, w_speed_b, w_set_speed;
    logic [fmsc_pkg::RAMP_W-1:0]       w_ramp_r;
    logic [fmsc_pkg::RAMP_W:0]         w_ramp_inc;
    fmsc_pkg::t_mode                   w_mode_b;

    function automatic t_rule apply_rule(
        input fmsc_pkg::t_mode             mode,
        input logic [fmsc_pkg::DUTY_W-1:0] speed,
        input logic [fmsc_pkg::DUTY_W-1:0] duty,
        input logic                        led,
        input logic                        lock,
        input logic                        present,
        input logic                        hot,
        input logic [fmsc_pkg::DUTY_W-1:0] strength
    );
        t_rule rr;
        logic  run;
        rr  = '{speed: speed, duty: duty, led: led};
        run = 1'b0;
        case (mode)
            fmsc_pkg::MODE_MANUAL: begin
                rr.duty = speed;
                if (!lock) rr.led = (speed != '0);
            end
            fmsc_pkg::MODE_PRESENCE, fmsc_pkg::MODE_THRESHOLD: begin
                run      = (mode == fmsc_pkg::MODE_PRESENCE) ? present : hot;
                rr.speed = run ? strength : '0;
                rr.duty  = rr.speed;
                if (!lock) rr.led = run;
            end
            default: ;
        endcase
        return rr;
    endfunction

    // Threshold compares on exact hundredths
    assign w_temp_lim = fmsc_pkg::CMP_W'(
        fmsc_pkg::CMP_W'(i_cfg.temp_th) * fmsc_pkg::HUNDRED);
    assign w_hum_lim  = fmsc_pkg::CMP_W'(
        fmsc_pkg::CMP_W'(i_cfg.hum_th) * fmsc_pkg::HUNDRED);
    assign w_temp = fmsc_pkg::CMP_W'(i_item.temperature);
    assign w_hum  = $signed({{(fmsc_pkg::CMP_W - fmsc_pkg::HUM_W){1'b0}}, i_item.humidity});
    assign w_hot  = (w_temp > w_temp_lim) || (w_hum > w_hum_lim);

    // Tick: first rule application
    assign w_rule_a = apply_rule(r_mode, r_speed, r_duty, r_led, r_lock,
                                 i_item.presence, w_hot, i_cfg.strength);

    // Tick: manual ramp
    assign w_ramp_inc = {1'b0, r_ramp} + (fmsc_pkg::RAMP_W + 1)'(1);
    always_comb begin
        w_speed_r = w_rule_a.speed;
        w_ramp_r  = r_ramp;
        if (r_mode == fmsc_pkg::MODE_MANUAL && i_item.presence && w_rule_a.speed != '0) begin
            if (w_ramp_inc >= (fmsc_pkg::RAMP_W + 1)'(fmsc_pkg::RAMP_PERIOD)) begin
                w_speed_r = w_rule_a.speed + fmsc_pkg::DUTY_W'(1);
                w_ramp_r  = fmsc_pkg::RAMP_W'(1);
            end else begin
                w_ramp_r  = w_ramp_inc[fmsc_pkg::RAMP_W-1:0];
            end
            if (w_speed_r >= fmsc_pkg::DUTY_MAX) w_speed_r = '0;
        end
    end

    // Tick: button step
    always_comb begin
        w_mode_b  = r_mode;
        w_speed_b = w_speed_r;
        case (r_mode)
            fmsc_pkg::MODE_PRESENCE: begin
                w_mode_b  = fmsc_pkg::MODE_THRESHOLD;
                w_speed_b = '0;
            end
            fmsc_pkg::MODE_THRESHOLD: begin
                w_mode_b  = fmsc_pkg::MODE_MANUAL;
                w_speed_b = '0;
            end
            default: begin
                if (w_speed_r == '0) begin
                    w_speed_b = fmsc_pkg::DUTY_W'(1);
                end else if (w_speed_r >= fmsc_pkg::BUTTON_TOP) begin
                    w_mode_b = fmsc_pkg::MODE_PRESENCE;
                end else begin
                    w_speed_b = w_speed_r + fmsc_pkg::BUTTON_STEP;
                end
            end
        endcase
    end

    // Tick: second rule application after the button
    assign w_rule_b = apply_rule(w_mode_b, w_speed_b, w_rule_a.duty, w_rule_a.led, r_lock,
                                 i_item.presence, w_hot, i_cfg.strength);

    assign w_set_speed = (i_item.setting_value > fmsc_pkg::DUTY_MAX) ?
                         fmsc_pkg::DUTY_MAX : i_item.setting_value;

    // Next state per command
    always_comb begin
        n_mode   = r_mode;
        n_speed  = r_speed;
        n_ramp   = r_ramp;
        n_lock   = r_lock;
        n_led    = r_led;
        n_duty   = r_duty;
        w_status = fmsc_pkg::ST_OK;
        unique case (i_item.command)
            fmsc_pkg::CMD_TICK: begin
                n_ramp = w_ramp_r;
                if (i_item.button_pressed) begin
                    n_mode  = w_mode_b;
                    n_speed = w_rule_b.speed;
                    n_duty  = w_rule_b.duty;
                    n_led   = w_rule_b.led;
                end else begin
                    n_speed = w_speed_r;
                    n_duty  = w_rule_a.duty;
                    n_led   = w_rule_a.led;
                end
            end
            fmsc_pkg::CMD_SET_SPEED: begin
                n_speed = w_set_speed;
                n_mode  = fmsc_pkg::MODE_MANUAL;
                n_duty  = w_set_speed;
            end
            fmsc_pkg::CMD_LED: begin
                if (i_item.setting_value == fmsc_pkg::LED_OFF ||
                    i_item.setting_value == fmsc_pkg::LED_ON) begin
                    n_led  = i_item.setting_value[0];
                    n_lock = 1'b1;
                end else if (i_item.setting_value == fmsc_pkg::LED_UNLOCK) begin
                    n_led  = 1'b0;
                    n_lock = 1'b0;
                end else begin
                    w_status = fmsc_pkg::ST_BAD_LED;
                end
            end
            fmsc_pkg::CMD_SET_MODE: begin
                if (i_item.setting_value > fmsc_pkg::VAL_W'(fmsc_pkg::MODE_MANUAL)) begin
                    w_status = fmsc_pkg::ST_BAD_MODE;
                end else begin
                    n_mode = fmsc_pkg::t_mode'(i_item.setting_value[fmsc_pkg::MODE_W-1:0]);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= fmsc_pkg::MODE_PRESENCE;
            r_speed <= '0;
            r_ramp  <= fmsc_pkg::RAMP_W'(1);
            r_lock  <= 1'b0;
            r_led   <= 1'b0;
            r_duty  <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_speed <= n_speed;
            r_ramp  <= n_ramp;
            r_lock  <= n_lock;
            r_led   <= n_led;
            r_duty  <= n_duty;
        end
    end

    assign o_result.fan_duty      = n_duty;
    assign o_result.fan_led       = n_led;
    assign o_result.current_mode  = n_mode;
    assign o_result.speed_setting = n_speed;
    assign o_result.status        = w_status;

endmodule

// ===== rtl/fmsc_out_stage.sv =====
`timescale 1ns / 1ps

module fmsc_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  fmsc_pkg::t_result   i_result,
    output logic                o_room,     // can load a result this cycle
    output logic                o_valid,
    input  logic                i_ready,
    output fmsc_pkg::t_result   o_result
);

    logic              r_valid;
    fmsc_pkg::t_result r_result;

    assign o_room = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/fan_mode_speed_controller.sv =====
`timescale 1ns / 1ps

// Fan controller with presence, threshold and manual modes. Each input
// transaction (tick, set speed, LED control or set mode, chosen by tuser) gives
// exactly one result transaction with the driven PWM duty, LED state, mode,
// stored speed and a status code. One transaction is accepted per clock while
// the result side takes results; each transaction passes through the input
// register and then the result register, and all work for a transaction is
// done combinationally between those two registers. Backpressure on the result
// side stalls the input side only once both registers are full. Configuration
// writes are always accepted (o_cfg_ready is tied high) and must be made while
// no transaction is in flight.
module fan_mode_speed_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // presence[0], temperature[15:1], humidity[29:16], button_pressed[30],
    // setting_value[37:31], zero fill above
    input  logic [fmsc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // command[1:0]
    input  logic [fmsc_pkg::CMD_W-1:0]           s_axis_tuser,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // fan_duty[6:0], fan_led[7], current_mode[9:8], speed_setting[16:10],
    // status[18:17], zero fill above
    output logic [fmsc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fmsc_pkg::CIDX_W-1:0]          i_cfg_index,
    input  logic [fmsc_pkg::CDATA_W-1:0]         i_cfg_data
);

    fmsc_pkg::t_cfg    w_cfg;
    fmsc_pkg::t_item   w_in_item, w_held_item;
    fmsc_pkg::t_result w_core_result, w_out_result;
    logic              w_held_valid, w_out_room, w_fire;

    // Unpack the input stream
    assign w_in_item.command        = fmsc_pkg::t_cmd'(s_axis_tuser);
    assign w_in_item.presence       = s_axis_tdata[0];
    assign w_in_item.temperature    = s_axis_tdata[15:1];
    assign w_in_item.humidity       = s_axis_tdata[29:16];
    assign w_in_item.button_pressed = s_axis_tdata[30];
    assign w_in_item.setting_value  = s_axis_tdata[37:31];

    fmsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    fmsc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_item  (w_in_item),
        .o_ready (s_axis_tready),
        .i_take  (w_fire),
        .o_valid (w_held_valid),
        .o_item  (w_held_item)
    );

    // Process the held transaction when the result register has room
    assign w_fire = w_held_valid && w_out_room;

    fmsc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_fire   (w_fire),
        .i_item   (w_held_item),
        .o_result (w_core_result)
    );

    fmsc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_result (w_core_result),
        .o_room   (w_out_room),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out_result)
    );

    // Pack the result stream
    assign m_axis_tdata = {{(fmsc_pkg::OUT_DATA_W - fmsc_pkg::OUT_BITS){1'b0}},
                           w_out_result.status,
                           w_out_result.speed_setting,
                           w_out_result.current_mode,
                           w_out_result.fan_led,
                           w_out_result.fan_duty};

endmodule
